// ----- src/dmg_pkg.sv -----
// Shared types and constants for the depth min/max to gray converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package dmg_pkg;

    localparam int DEPTH_W     = 16;
    localparam int GRAY_W      = 8;
    localparam int NUM_W       = DEPTH_W + GRAY_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = GRAY_W + 1;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = {DEPTH_W{1'b1}};
    localparam logic [DEPTH_W-1:0] DEPTH_ZERO  = '0;
    localparam logic [DEPTH_W-1:0] RANGE_RESET = DEPTH_W'(1);
    localparam logic [GRAY_W-1:0]  GRAY_MAX    = {GRAY_W{1'b1}};

    typedef struct packed {
        logic [DEPTH_W-1:0] diff;
        logic [DEPTH_W-1:0] range;
        logic               last;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_HOLD
    } t_back_state;

endpackage

// ----- src/dmg_if.sv -----
// Valid/ready stream interfaces for the sample input and the gray output.
// Depends on dmg_pkg for the field widths.
`timescale 1ns / 1ps
interface dmg_in_if;
    import dmg_pkg::*;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [DEPTH_W-1:0] depth;
    logic               last;
    modport source (output valid, output mode, output depth, output last, input ready);
    modport sink (input valid, input mode, input depth, input last, output ready);
endinterface

interface dmg_out_if;
    import dmg_pkg::*;
    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] gray;
    logic              last_res;
    modport source (output valid, output gray, output last_res, input ready);
    modport sink (input valid, input gray, input last_res, output ready);
endinterface

// ----- src/depth_minmax_to_gray.sv -----
// Depth min/max normalization to gray. Measure samples are taken one per cycle
// while the job queue has room. A convert sample's gray byte comes from the
// bit-serial divider (load, nine quotient steps, then hand-off to the output
// register), which works on one job at a time while the queue holds more jobs.
// Synchronous active-low reset restores min 65535 and range 1 and empties
// the queue and the output register.
`timescale 1ns / 1ps
module depth_minmax_to_gray
    import dmg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmg_in_if.sink    i_in,
    dmg_out_if.source o_out
);

    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    dmg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    dmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    dmg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ----- src/dmg_front.sv -----
// Front end: accepts samples, tracks min/max in the measure pass and turns
// convert samples into division jobs. Depends on dmg_pkg and dmg_if.
`timescale 1ns / 1ps
module dmg_front
    import dmg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    dmg_in_if.sink i_in,
    input  logic  i_full,
    output logic  o_push,
    output t_job  o_job
);

    logic [DEPTH_W-1:0] r_run_min, n_run_min;
    logic [DEPTH_W-1:0] r_run_max, n_run_max;
    logic [DEPTH_W-1:0] r_frame_min;
    logic [DEPTH_W-1:0] r_frame_range;
    logic [DEPTH_W-1:0] n_range;
    logic               w_xfer;
    logic               w_measure;
    logic               w_below;

    assign i_in.ready = !i_full;
    assign w_xfer     = i_in.valid && i_in.ready;
    assign w_measure  = w_xfer && !i_in.mode;

    always_comb begin
        n_run_min = r_run_min;
        n_run_max = r_run_max;
        if (i_in.depth != DEPTH_ZERO) begin
            if (i_in.depth < r_run_min) begin
                n_run_min = i_in.depth;
            end
            if (i_in.depth > r_run_max) begin
                n_run_max = i_in.depth;
            end
        end
        n_range = (n_run_max > n_run_min) ? (n_run_max - n_run_min) : RANGE_RESET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min     <= DEPTH_MAX;
            r_run_max     <= DEPTH_ZERO;
            r_frame_min   <= DEPTH_MAX;
            r_frame_range <= RANGE_RESET;
        end else if (w_measure) begin
            if (i_in.last) begin
                r_frame_min   <= n_run_min;
                r_frame_range <= n_range;
                r_run_min     <= DEPTH_MAX;
                r_run_max     <= DEPTH_ZERO;
            end else begin
                r_run_min <= n_run_min;
                r_run_max <= n_run_max;
            end
        end
    end

    // A zero sample or one below the minimum yields a zero numerator.
    assign w_below     = (i_in.depth == DEPTH_ZERO) || (i_in.depth < r_frame_min);
    assign o_push      = w_xfer && i_in.mode;
    assign o_job.diff  = w_below ? DEPTH_ZERO : (i_in.depth - r_frame_min);
    assign o_job.range = r_frame_range;
    assign o_job.last  = i_in.last;

endmodule

// ----- src/dmg_queue.sv -----
// Short job queue between the front end and the divider.
// Depends on dmg_pkg for the job type and the queue depth.
`timescale 1ns / 1ps
module dmg_queue
    import dmg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ----- src/dmg_back.sv -----
// Back end: restoring divider that scales one job to a gray byte, one
// quotient bit per cycle, plus the output register. Depends on dmg_pkg, dmg_if.
`timescale 1ns / 1ps
module dmg_back
    import dmg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    dmg_out_if.source  o_out
);

    t_back_state          r_state, n_state;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_STEPS-1:0] r_quo;
    logic                 r_last;
    logic                 r_out_valid;
    logic [GRAY_W-1:0]    r_gray;
    logic                 r_out_last;
    logic                 w_load;
    logic                 w_step;
    logic                 w_out_load;
    logic                 w_out_free;
    logic                 w_ge;
    logic [NUM_W-1:0]     w_num;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ge       = (r_rem >= r_div);
    assign w_num      = {i_job.diff, GRAY_W'(0)} - {GRAY_W'(0), i_job.diff};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_cnt == '0) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_load     = 1'b0;
        w_step     = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            BK_IDLE: w_load     = !i_empty;
            BK_RUN:  w_step     = 1'b1;
            BK_HOLD: w_out_load = w_out_free;
            default: ;
        endcase
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The first step tests for a quotient of 256 or more, which saturates.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem  <= w_num;
            r_div  <= {i_job.range, GRAY_W'(0)};
            r_cnt  <= CNT_W'(DIV_STEPS - 1);
            r_quo  <= '0;
            r_last <= i_job.last;
        end else if (w_step) begin
            r_rem <= w_ge ? (r_rem - r_div) : r_rem;
            r_div <= r_div >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
            r_quo <= {r_quo[DIV_STEPS-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_gray     <= r_quo[DIV_STEPS-1] ? GRAY_MAX : r_quo[GRAY_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.gray     = r_gray;
    assign o_out.last_res = r_out_last;

endmodule
